// ===== rtl/core/dsm_pkg.sv =====
// Shared types and constants for the dot-star pattern matcher.
`timescale 1ns / 1ps

package dsm_pkg;

  // Pattern geometry: one row bit per pattern prefix, including the empty one.
  localparam int PATTERN_MAX = 16;
  localparam int ROW_W       = PATTERN_MAX + 1;
  localparam int LEN_W       = $clog2(ROW_W);
  localparam int CHARS_W     = PATTERN_MAX * 8;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 2;

  // Special pattern bytes.
  localparam logic [7:0] STAR_BYTE = 8'h2A;
  localparam logic [7:0] DOT_BYTE  = 8'h2E;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_CHARS_LOW  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CHARS_HIGH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_LENGTH     = 2'd2;

  // Input action codes.
  localparam logic ACT_START  = 1'b0;
  localparam logic ACT_APPEND = 1'b1;

  // Control handed from the top level to the row of cells.
  typedef struct packed {
    logic step;    // an item is accepted this cycle
    logic append;  // the item appends a byte (else it starts a new subject)
  } row_ctl_t;

endpackage

// ===== rtl/core/dsm_cell.sv =====
// One column cell of the match row: computes the next bit for one pattern prefix.
`timescale 1ns / 1ps

module dsm_cell (
  input  dsm_pkg::row_ctl_t ctl,
  input  logic [7:0]        subject_byte,
  input  logic [7:0]        pat_byte,
  input  logic [7:0]        prev_byte,
  input  logic              lead,
  input  logic              old_left,
  input  logic              old_self,
  input  logic              ripple_in,
  output logic              bit_next
);
  import dsm_pkg::*;

  logic pat_hit;
  logic prev_hit;

  // Byte comparisons against this column's pattern byte and the one before it.
  assign pat_hit  = (subject_byte == pat_byte) || (pat_byte == DOT_BYTE);
  assign prev_hit = (subject_byte == prev_byte) || (prev_byte == DOT_BYTE);

  // A star column either skips its pair (taken from two columns back in the
  // new row) or repeats the byte before it; a leading star never matches.
  // A plain column extends the diagonal from the old row.
  always_comb begin
    if (pat_byte == STAR_BYTE) begin
      bit_next = !lead && (ripple_in || (ctl.append && prev_hit && old_self));
    end else begin
      bit_next = ctl.append && old_left && pat_hit;
    end
  end

endmodule

// ===== rtl/core/dsm_row.sv =====
// Chain of column cells and the stored match row.
`timescale 1ns / 1ps

module dsm_row (
  input  logic                      clk,
  input  logic                      rst,
  input  dsm_pkg::row_ctl_t         ctl,
  input  logic [7:0]                subject_byte,
  input  logic [dsm_pkg::CHARS_W-1:0] pattern_chars,
  input  logic [dsm_pkg::LEN_W-1:0] len,
  output logic                      match_next
);
  import dsm_pkg::*;

  logic [ROW_W-1:0] match_row;
  logic [ROW_W-1:0] match_row_next;

  // The empty prefix matches only the empty subject.
  assign match_row_next[0] = !ctl.append;

  // One cell per pattern prefix; star columns ripple from two cells back.
  for (genvar j = 1; j <= PATTERN_MAX; j++) begin : g_cell
    logic [7:0] prev_byte;
    logic       ripple_in;

    if (j == 1) begin : g_first
      assign prev_byte = 8'h00;
      assign ripple_in = 1'b0;
    end else begin : g_rest
      assign prev_byte = pattern_chars[8*(j-2) +: 8];
      assign ripple_in = match_row_next[j-2];
    end

    dsm_cell u_cell (
      .ctl          (ctl),
      .subject_byte (subject_byte),
      .pat_byte     (pattern_chars[8*(j-1) +: 8]),
      .prev_byte    (prev_byte),
      .lead         (j == 1),
      .old_left     (match_row[j-1]),
      .old_self     (match_row[j]),
      .ripple_in    (ripple_in),
      .bit_next     (match_row_next[j])
    );
  end

  // Result for the item: the column of the whole pattern.
  assign match_next = match_row_next[len];

  // Row state; reset leaves only the empty prefix matching.
  always_ff @(posedge clk) begin
    if (rst) begin
      match_row <= ROW_W'(1);
    end else if (ctl.step) begin
      match_row <= match_row_next;
    end
  end

endmodule

// ===== rtl/core/dot_star_pattern_matcher_core.sv =====
// Top level of the dot-star pattern matcher: configuration, handshake, result register.
//
//   Channel  | Signals                                   | Direction
//   ---------+-------------------------------------------+----------
//   input    | in_valid, in_stall, action, subject_byte  | in
//   output   | out_valid, out_stall, matched             | out
//   config   | cfg_write, cfg_index, cfg_data            | in
//
// The cell chain updates the whole row in the cycle an item is accepted, and its
// result is in the output register next cycle.
// Throughput is one item per cycle while the output is being taken.
// Reset is synchronous; it clears the configuration and leaves only the empty
// prefix matching. While a result waits under out_stall, in_stall is raised.
`timescale 1ns / 1ps

module dot_star_pattern_matcher_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [dsm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dsm_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          action,
  input  logic [7:0]                    subject_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          matched
);
  import dsm_pkg::*;

  logic [CFG_DATA_W-1:0] pattern_chars_low;
  logic [CFG_DATA_W-1:0] pattern_chars_high;
  logic [LEN_W-1:0]      pattern_length;
  logic [LEN_W-1:0]      len_eff;
  row_ctl_t              ctl;
  logic                  match_next;

  // Configuration registers; writes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_chars_low  <= '0;
      pattern_chars_high <= '0;
      pattern_length     <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_CHARS_LOW:  pattern_chars_low  <= cfg_data;
        CFG_CHARS_HIGH: pattern_chars_high <= cfg_data;
        CFG_LENGTH:     pattern_length     <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Lengths above the pattern bound count as the bound.
  assign len_eff = (pattern_length > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX)
                                                          : pattern_length;

  // Accept an item whenever the output register is free or being emptied.
  assign in_stall   = out_valid && out_stall;
  assign ctl.step   = in_valid && !in_stall;
  assign ctl.append = (action == ACT_APPEND);

  dsm_row u_row (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .subject_byte  (subject_byte),
    .pattern_chars ({pattern_chars_high, pattern_chars_low}),
    .len           (len_eff),
    .match_next    (match_next)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      matched <= match_next;
    end
  end

endmodule

// ===== rtl/core/dsm_checker.sv =====
// Port-level checks for the dot-star pattern matcher, bound to the top level.
`timescale 1ns / 1ps

module dsm_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic matched
);

  // A result held under stall stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(matched))
    else $error("result changed while stalled");

  // Every accepted item shows a result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted item produced no result");

  // The input stalls only while a result waits to be taken.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with the output free");

endmodule

bind dot_star_pattern_matcher_core dsm_checker u_dsm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .matched   (matched)
);

// ===== test/tb_dot_star_pattern_matcher_core.sv =====
// Self-checking testbench for the dot-star pattern matcher core.
`timescale 1ns / 1ps

module tb_dot_star_pattern_matcher_core;
  import dsm_pkg::*;

  // One subject item as the sender presents it.
  typedef struct {
    logic       act;
    logic [7:0] chr;
  } subject_item_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   action = 1'b0;
  logic [7:0]             subject_byte = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic                   matched;

  // Shadow of the configuration and of the match row kept by the block.
  logic [CHARS_W-1:0] pat_chars = '0;
  logic [4:0]         pat_len = '0;
  logic [ROW_W-1:0]   match_row = 1;

  subject_item_t pending_items[$];
  logic          expected_matched[$];
  subject_item_t next_item;

  bit idling = 1'b0;
  int send_gap = 0;
  int recv_gap = 0;
  int fail_count = 0;
  int items_queued = 0;
  int items_accepted = 0;
  int results_checked = 0;
  int matches_seen = 0;
  int phase_count = 0;
  int random_base;
  int n_subjects;
  int pick;
  int gen_len;
  logic [CHARS_W-1:0] gen_chars;
  logic want;

  dot_star_pattern_matcher_core DUT (.*);

  always #10 clk = ~clk;

  function automatic logic [7:0] pattern_byte(input int k);
    return pat_chars[k*8 +: 8];
  endfunction

  // Advance the shadow match row by one item and return the expected match bit.
  function automatic logic advance_match_row(input logic act, input logic [7:0] chr);
    logic [ROW_W-1:0] nrow;
    logic [7:0]       p;
    logic [7:0]       x;
    int               eff_len;
    nrow = '0;
    if (act == ACT_START) begin
      // Empty subject: only star pairs can match, by taking zero repeats.
      nrow[0] = 1'b1;
      for (int j = 2; j <= PATTERN_MAX; j++) begin
        if (pattern_byte(j - 1) == STAR_BYTE && nrow[j-2]) nrow[j] = 1'b1;
      end
    end else begin
      for (int j = 1; j <= PATTERN_MAX; j++) begin
        p = pattern_byte(j - 1);
        if (p != STAR_BYTE) begin
          nrow[j] = match_row[j-1] && (chr == p || p == DOT_BYTE);
        end else if (j >= 2) begin
          // A star either drops its pair or repeats the byte before it.
          x = pattern_byte(j - 2);
          nrow[j] = nrow[j-2] || ((chr == x || x == DOT_BYTE) && match_row[j]);
        end
      end
    end
    match_row = nrow;
    eff_len = (pat_len > PATTERN_MAX) ? PATTERN_MAX : pat_len;
    return nrow[eff_len];
  endfunction

  function automatic logic [CHARS_W-1:0] pack_text(input string s);
    logic [CHARS_W-1:0] r;
    r = '0;
    for (int k = 0; k < s.len(); k++) r[k*8 +: 8] = s[k];
    return r;
  endfunction

  // Pattern bytes are drawn mostly from a small alphabet so that matches happen.
  function automatic logic [7:0] pick_pattern_byte();
    case ($urandom_range(0, 9))
      0, 1: return "a";
      2: return "b";
      3: return "c";
      4, 5: return DOT_BYTE;
      6, 7: return STAR_BYTE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic push_item(input logic act, input logic [7:0] chr);
    subject_item_t it;
    it.act = act;
    it.chr = chr;
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      CFG_CHARS_LOW:  pat_chars[63:0] = data;
      CFG_CHARS_HIGH: pat_chars[127:64] = data;
      CFG_LENGTH:     pat_len = data[4:0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic load_pattern(input logic [CHARS_W-1:0] chars, input logic [4:0] len);
    write_reg(CFG_CHARS_LOW, chars[63:0]);
    write_reg(CFG_CHARS_HIGH, chars[127:64]);
    write_reg(CFG_LENGTH, CFG_DATA_W'(len));
    end_writes();
  endtask

  // The sender holds off until every queued item has been answered.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_matched.size() != 0);
  endtask

  // Queue subject bytes that follow the current pattern, with some corruption.
  task automatic queue_subject();
    int         walk;
    int         reps;
    logic [7:0] p;
    logic [7:0] c;
    walk = (pat_len > PATTERN_MAX) ? PATTERN_MAX : pat_len;
    for (int k = 0; k < walk; k++) begin
      p = pattern_byte(k);
      if (k + 1 < walk && pattern_byte(k + 1) == STAR_BYTE) begin
        reps = $urandom_range(0, 3);
        k++;
      end else if (p == STAR_BYTE) begin
        reps = $urandom_range(0, 2);
      end else begin
        reps = 1;
      end
      for (int r = 0; r < reps; r++) begin
        c = (p == DOT_BYTE) ? 8'($urandom_range(0, 255)) : p;
        if ($urandom_range(0, 11) == 0) c = 8'($urandom_range(0, 255));
        push_item(ACT_APPEND, c);
      end
    end
    // Occasionally run past the end of the pattern.
    if ($urandom_range(0, 3) == 0) begin
      for (int r = $urandom_range(1, 3); r > 0; r--) push_item(ACT_APPEND, pick_pattern_byte());
    end
  endtask

  // Driver: presents queued items and predicts each accepted one.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_matched.push_back(advance_match_row(action, subject_byte));
        items_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          next_item = pending_items.pop_front();
          in_valid     <= 1'b1;
          action       <= next_item.act;
          subject_byte <= next_item.chr;
          if (idling && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 16);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result and stalls the output in bursts.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      recv_gap = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_matched.size() == 0) begin
          $error("result with no item outstanding: matched=%0b", matched);
          fail_count++;
        end else begin
          want = expected_matched.pop_front();
          if (matched !== want) begin
            $error("matched: expected %0b, actual %0b", want, matched);
            fail_count++;
          end
          results_checked++;
          if (matched === 1'b1) matches_seen++;
        end
      end
      if (recv_gap != 0) begin
        recv_gap--;
        out_stall <= 1'b1;
      end else if (idling && $urandom_range(0, 11) == 0) begin
        recv_gap = $urandom_range(0, 15);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Main sequence: reset, directed phases, then random phases.
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    idling = 1'b1;

    // Appending right after reset continues from the reset row.
    load_pattern(pack_text("a.b*"), 5'd4);
    push_item(ACT_APPEND, "a");
    push_item(ACT_APPEND, "x");
    push_item(ACT_APPEND, "b");
    push_item(ACT_APPEND, "b");
    push_item(ACT_START, 8'hFF);
    push_item(ACT_APPEND, "a");
    push_item(ACT_APPEND, "z");

    // A star in the first byte, and a star that follows another star.
    wait_idle();
    load_pattern(pack_text("*a**"), 5'd4);
    push_item(ACT_START, 8'h00);
    push_item(ACT_APPEND, "a");
    push_item(ACT_APPEND, "*");
    push_item(ACT_APPEND, "*");
    push_item(ACT_START, "*");

    // Length above the bound, changed in the middle of a subject.
    wait_idle();
    write_reg(CFG_LENGTH, CFG_DATA_W'(31));
    end_writes();
    push_item(ACT_APPEND, "a");
    push_item(ACT_START, 8'h55);

    // All-ones and all-zero pattern words at the length extremes.
    wait_idle();
    load_pattern('1, 5'd16);
    push_item(ACT_APPEND, 8'hFF);
    push_item(ACT_START, 8'hAA);
    push_item(ACT_APPEND, 8'h00);
    wait_idle();
    load_pattern('0, 5'd0);
    push_item(ACT_START, 8'h00);
    push_item(ACT_APPEND, 8'h00);
    wait_idle();
    load_pattern(pack_text(".*c"), 5'd3);
    push_item(ACT_START, 8'h00);
    push_item(ACT_APPEND, "c");
    phase_count = 6;

    // Random phases: each one may reconfigure, then streams one to five subjects.
    random_base = items_queued;
    while (items_queued - random_base < 1250) begin
      wait_idle();
      phase_count++;
      idling = (items_queued - random_base < 1100) && ($urandom_range(0, 4) != 0);
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        write_reg(CFG_LENGTH, CFG_DATA_W'($urandom_range(0, 31)));
        end_writes();
      end else if (pick == 1) begin
        load_pattern({$urandom, $urandom, $urandom, $urandom}, 5'($urandom_range(0, 31)));
      end else if (pick != 2) begin
        case ($urandom_range(0, 9))
          0: gen_len = 0;
          1: gen_len = 16;
          2: gen_len = $urandom_range(17, 31);
          default: gen_len = $urandom_range(1, 16);
        endcase
        for (int k = 0; k < PATTERN_MAX; k++) gen_chars[k*8 +: 8] = pick_pattern_byte();
        load_pattern(gen_chars, 5'(gen_len));
      end
      // Most subjects open with a start; some continue the previous row.
      n_subjects = $urandom_range(1, 5);
      for (int s = 0; s < n_subjects; s++) begin
        if ($urandom_range(0, 4) != 0) push_item(ACT_START, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 7) == 0) begin
          for (int r = $urandom_range(1, 8); r > 0; r--)
            push_item(ACT_APPEND, 8'($urandom_range(0, 255)));
        end else begin
          queue_subject();
        end
      end
    end

    wait_idle();
    repeat (4) @(posedge clk);
    $display("Checked %0d results for %0d items over %0d pattern phases; %0d matched.",
             results_checked, items_accepted, phase_count, matches_seen);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #10ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== dot_star_pattern_matcher_core.f =====
rtl/core/dsm_pkg.sv
rtl/core/dsm_cell.sv
rtl/core/dsm_row.sv
rtl/core/dot_star_pattern_matcher_core.sv
rtl/core/dsm_checker.sv
test/tb_dot_star_pattern_matcher_core.sv
